// ===== rtl/core/gfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gfpm_pkg
// Types, constants and the segment table shared by the gated frequency and
// period meter.
// ----------------------------------------------------------------------------
package gfpm_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_GATE_TICKS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_MASK     = 2'd2;

    localparam logic [31:0] GATE_RESET     = 32'h0501_BD00;
    localparam logic [23:0] DEBOUNCE_RESET = 24'd65535;
    localparam logic [15:0] POINT_RESET    = 16'h2000;

    localparam int unsigned DISPLAY_MAX = 9999;
    localparam int unsigned VALUE_W     = 14;

    localparam logic [1:0] POINT_NONE      = 2'd0;
    localparam logic [1:0] POINT_THOUSANDS = 2'd1;
    localparam logic [1:0] POINT_HUNDREDS  = 2'd2;
    localparam logic [1:0] POINT_TENS      = 2'd3;

    typedef struct packed {
        logic [31:0]        count;
        logic [VALUE_W-1:0] value;
        logic               mode;
    } job_t;

    function automatic logic [15:0] digit_seg(input logic [3:0] digit);
        logic [15:0] word;
        word = 16'h0000;
        unique case (digit)
            4'd0:    word = 16'h5446;
            4'd1:    word = 16'h0044;
            4'd2:    word = 16'h1452;
            4'd3:    word = 16'h1056;
            4'd4:    word = 16'h4054;
            4'd5:    word = 16'h5016;
            4'd6:    word = 16'h5416;
            4'd7:    word = 16'h1044;
            4'd8:    word = 16'h5456;
            4'd9:    word = 16'h5056;
            default: word = 16'h0000;
        endcase
        return word;
    endfunction

endpackage

// ===== rtl/core/gfpm_front.sv =====
// ----------------------------------------------------------------------------
// gfpm_front
// Tick front end: edge counting over the gate, button debounce and mode
// toggle, and queuing of one display job per gate close or toggle.
// ----------------------------------------------------------------------------
module gfpm_front #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick,
    input  logic           signal_edge,
    input  logic           button_level,
    input  logic [31:0]    gate_ticks,
    input  logic [23:0]    debounce_ticks,
    output logic           push,
    output gfpm_pkg::job_t job
);

    logic [COUNT_WIDTH-1:0] edge_tally_reg, edge_tally_next;
    logic [COUNT_WIDTH-1:0] latched_tally_reg, latched_tally_next;
    logic [31:0]            gate_elapsed_reg, gate_elapsed_next;
    logic [23:0]            settle_elapsed_reg, settle_elapsed_next;
    logic                   settle_running_reg, settle_running_next;
    logic                   button_before_reg, button_before_next;
    logic                   mode_flag_reg, mode_flag_next;

    logic [COUNT_WIDTH-1:0] tally_inc;
    logic [32:0]            gate_sum;
    logic [23:0]            settle_sum;
    logic                   closed;
    logic                   toggled;
    logic [COUNT_WIDTH+31:0] latched_ext;

    always_comb
    begin
        tally_inc = signal_edge ? edge_tally_reg + COUNT_WIDTH'(1) : edge_tally_reg;
        gate_sum = {1'b0, gate_elapsed_reg} + 33'd1;
        closed = gate_sum >= {1'b0, gate_ticks};
        settle_sum = settle_elapsed_reg + 24'd1;
        toggled = 1'b0;

        latched_tally_next = closed ? tally_inc : latched_tally_reg;
        edge_tally_next = closed ? '0 : tally_inc;
        gate_elapsed_next = closed ? 32'd0 : gate_sum[31:0];

        settle_elapsed_next = settle_elapsed_reg;
        settle_running_next = settle_running_reg;
        mode_flag_next = mode_flag_reg;
        if (button_before_reg && !button_level)
        begin
            settle_elapsed_next = 24'd0;
            settle_running_next = 1'b1;
        end
        else if (settle_running_reg)
        begin
            settle_elapsed_next = settle_sum;
            if (settle_sum >= debounce_ticks)
            begin
                settle_running_next = 1'b0;
                settle_elapsed_next = 24'd0;
                if (!button_level)
                begin
                    mode_flag_next = !mode_flag_reg;
                    toggled = 1'b1;
                end
            end
        end
        button_before_next = button_level;

        latched_ext = {32'd0, latched_tally_next};
        push = tick && (closed || toggled);
        job.count = latched_ext[31:0];
        job.value = (latched_tally_next > COUNT_WIDTH'(gfpm_pkg::DISPLAY_MAX))
                    ? gfpm_pkg::VALUE_W'(gfpm_pkg::DISPLAY_MAX)
                    : latched_tally_next[gfpm_pkg::VALUE_W-1:0];
        job.mode = mode_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_tally_reg     <= '0;
            latched_tally_reg  <= '0;
            gate_elapsed_reg   <= 32'd0;
            settle_elapsed_reg <= 24'd0;
            settle_running_reg <= 1'b0;
            button_before_reg  <= 1'b1;
            mode_flag_reg      <= 1'b0;
        end
        else if (tick)
        begin
            edge_tally_reg     <= edge_tally_next;
            latched_tally_reg  <= latched_tally_next;
            gate_elapsed_reg   <= gate_elapsed_next;
            settle_elapsed_reg <= settle_elapsed_next;
            settle_running_reg <= settle_running_next;
            button_before_reg  <= button_before_next;
            mode_flag_reg      <= mode_flag_next;
        end
    end

endmodule

// ===== rtl/core/gfpm_queue.sv =====
// ----------------------------------------------------------------------------
// gfpm_queue
// Two-entry job queue between the tick front end and the display back end.
// ----------------------------------------------------------------------------
module gfpm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gfpm_pkg::job_t push_job,
    input  logic           pop,
    output gfpm_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    gfpm_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           do_push;
    logic           do_pop;

    assign empty    = fill_reg == 2'd0;
    assign full     = fill_reg == 2'd2;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/gfpm_back.sv =====
// ----------------------------------------------------------------------------
// gfpm_back
// Display back end: period division, binary to BCD conversion, segment
// encoding and the output register.
// ----------------------------------------------------------------------------
module gfpm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  gfpm_pkg::job_t head_job,
    input  logic           queue_empty,
    output logic           pop,
    input  logic [15:0]    point_mask,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    measured_count,
    output logic           period_mode,
    output logic [15:0]    seg_thousands,
    output logic [15:0]    seg_hundreds,
    output logic [15:0]    seg_tens,
    output logic [15:0]    seg_units,
    output logic [1:0]     point_position
);

    localparam int unsigned QUOT_W     = 20;
    localparam int unsigned DIV_STEPS  = 20;
    localparam int unsigned CONV_STEPS = gfpm_pkg::VALUE_W;

    localparam logic [QUOT_W-1:0] DIVIDEND_TENS      = 20'd10000;
    localparam logic [QUOT_W-1:0] DIVIDEND_HUNDREDS  = 20'd100000;
    localparam logic [QUOT_W-1:0] DIVIDEND_THOUSANDS = 20'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LIMIT,
        ST_CONVERT,
        ST_DELIVER
    } state_t;

    state_t                        state_reg;
    logic [31:0]                   count_reg;
    logic                          mode_reg;
    logic                          keep_reg;
    logic [1:0]                    point_reg;
    logic [gfpm_pkg::VALUE_W-1:0]  divisor_reg;
    logic [gfpm_pkg::VALUE_W-1:0]  rem_reg;
    logic [QUOT_W-1:0]             quot_reg;
    logic [gfpm_pkg::VALUE_W-1:0]  bin_reg;
    logic [15:0]                   bcd_reg;
    logic [4:0]                    step_reg;
    logic                          out_valid_reg;
    logic [31:0]                   out_count_reg;
    logic                          out_mode_reg;
    logic [15:0]                   shown_words_reg [4];
    logic [1:0]                    shown_point_reg;

    logic [gfpm_pkg::VALUE_W:0]    trial;
    logic                          trial_ge;
    logic [gfpm_pkg::VALUE_W:0]    trial_diff;
    logic [15:0]                   bcd_adj;
    logic                          can_load;
    logic [15:0]                   new_word [4];

    always_comb
    begin
        trial = {rem_reg, quot_reg[QUOT_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        trial_diff = trial - {1'b0, divisor_reg};
        for (int i = 0; i < 4; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                           : bcd_reg[4*i +: 4];
        end
        for (int i = 0; i < 4; i++)
        begin
            new_word[i] = gfpm_pkg::digit_seg(bcd_reg[4*(3-i) +: 4]);
            if (i < 3 && point_reg == 2'(i + 1))
            begin
                new_word[i] = new_word[i] | point_mask;
            end
        end
        can_load = !out_valid_reg || out_ready;
        pop = (state_reg == ST_IDLE) && !queue_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= 32'd0;
            mode_reg        <= 1'b0;
            keep_reg        <= 1'b0;
            point_reg       <= gfpm_pkg::POINT_NONE;
            divisor_reg     <= '0;
            rem_reg         <= '0;
            quot_reg        <= '0;
            bin_reg         <= '0;
            bcd_reg         <= 16'd0;
            step_reg        <= 5'd0;
            out_valid_reg   <= 1'b0;
            out_count_reg   <= 32'd0;
            out_mode_reg    <= 1'b0;
            shown_words_reg <= '{default: 16'd0};
            shown_point_reg <= gfpm_pkg::POINT_NONE;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_DELIVER)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        count_reg <= head_job.count;
                        mode_reg  <= head_job.mode;
                        keep_reg  <= head_job.mode && (head_job.value == '0);
                        bcd_reg   <= 16'd0;
                        if (!head_job.mode)
                        begin
                            bin_reg   <= head_job.value;
                            point_reg <= gfpm_pkg::POINT_NONE;
                            step_reg  <= 5'(CONV_STEPS - 1);
                            state_reg <= ST_CONVERT;
                        end
                        else if (head_job.value == '0)
                        begin
                            state_reg <= ST_DELIVER;
                        end
                        else if (head_job.value == gfpm_pkg::VALUE_W'(1))
                        begin
                            bin_reg   <= gfpm_pkg::VALUE_W'(1000);
                            point_reg <= gfpm_pkg::POINT_NONE;
                            step_reg  <= 5'(CONV_STEPS - 1);
                            state_reg <= ST_CONVERT;
                        end
                        else
                        begin
                            divisor_reg <= head_job.value;
                            rem_reg     <= '0;
                            step_reg    <= 5'(DIV_STEPS - 1);
                            state_reg   <= ST_DIVIDE;
                            if (head_job.value <= gfpm_pkg::VALUE_W'(10))
                            begin
                                quot_reg  <= DIVIDEND_TENS;
                                point_reg <= gfpm_pkg::POINT_TENS;
                            end
                            else if (head_job.value <= gfpm_pkg::VALUE_W'(100))
                            begin
                                quot_reg  <= DIVIDEND_HUNDREDS;
                                point_reg <= gfpm_pkg::POINT_HUNDREDS;
                            end
                            else
                            begin
                                quot_reg  <= DIVIDEND_THOUSANDS;
                                point_reg <= gfpm_pkg::POINT_THOUSANDS;
                            end
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    rem_reg  <= trial_ge ? trial_diff[gfpm_pkg::VALUE_W-1:0]
                                         : trial[gfpm_pkg::VALUE_W-1:0];
                    quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= ST_LIMIT;
                    end
                end
                ST_LIMIT:
                begin
                    bin_reg <= (quot_reg > QUOT_W'(gfpm_pkg::DISPLAY_MAX))
                               ? gfpm_pkg::VALUE_W'(gfpm_pkg::DISPLAY_MAX)
                               : quot_reg[gfpm_pkg::VALUE_W-1:0];
                    bcd_reg   <= 16'd0;
                    step_reg  <= 5'(CONV_STEPS - 1);
                    state_reg <= ST_CONVERT;
                end
                ST_CONVERT:
                begin
                    bcd_reg  <= {bcd_adj[14:0], bin_reg[gfpm_pkg::VALUE_W-1]};
                    bin_reg  <= {bin_reg[gfpm_pkg::VALUE_W-2:0], 1'b0};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_count_reg <= count_reg;
                        out_mode_reg  <= mode_reg;
                        if (!keep_reg)
                        begin
                            shown_words_reg <= new_word;
                            shown_point_reg <= point_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign measured_count = out_count_reg;
    assign period_mode    = out_mode_reg;
    assign seg_thousands  = shown_words_reg[0];
    assign seg_hundreds   = shown_words_reg[1];
    assign seg_tens       = shown_words_reg[2];
    assign seg_units      = shown_words_reg[3];
    assign point_position = shown_point_reg;

    a_divisor_above_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (divisor_reg > gfpm_pkg::VALUE_W'(1)))
        else $error("divider running with a divisor below two");

    a_keep_only_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && keep_reg) |-> mode_reg)
        else $error("digits held over in frequency mode");

    a_delivery_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && can_load) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("delivered result did not reach the output register");

endmodule

// ===== rtl/core/gated_frequency_period_meter.sv =====
// ----------------------------------------------------------------------------
// gated_frequency_period_meter
// Counts signal edges over a programmable gate, toggles between frequency
// and period display on a debounced button press and emits four
// seven-segment words per gate close or mode toggle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         one tick: signal edge flag, button level
//  m_axis    out        one display result per gate close or mode toggle
//  cfg       in         register write: gate length, debounce length, point mask
//
// A tick is taken every cycle while the two-entry job queue has room.
// In the display unit, frequency mode and a period count of one take only the
// 14-step BCD conversion; a period count above one takes the 20-step divider,
// the clamp to 9999 and the BCD conversion; a zero period count goes to delivery.
// The output register lets the next job run while a result waits.
// Reset is asynchronous and active low; all counters and the display clear.
// ----------------------------------------------------------------------------
module gated_frequency_period_meter #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] signal_edge, [1] button_level, [7:2] zero
    input  logic [7:0]                         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] measured_count, [32] period_mode, [48:33] seg_thousands,
    // [64:49] seg_hundreds, [80:65] seg_tens, [96:81] seg_units,
    // [98:97] point_position, [103:99] zero
    output logic [103:0]                       m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [gfpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gfpm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [31:0]    gate_ticks_reg;
    logic [23:0]    debounce_ticks_reg;
    logic [15:0]    point_mask_reg;

    logic           tick;
    logic           push;
    gfpm_pkg::job_t push_job;
    gfpm_pkg::job_t head_job;
    logic           queue_empty;
    logic           queue_full;
    logic           pop;

    logic [31:0]    measured_count;
    logic           period_mode;
    logic [15:0]    seg_thousands;
    logic [15:0]    seg_hundreds;
    logic [15:0]    seg_tens;
    logic [15:0]    seg_units;
    logic [1:0]     point_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_ticks_reg     <= gfpm_pkg::GATE_RESET;
            debounce_ticks_reg <= gfpm_pkg::DEBOUNCE_RESET;
            point_mask_reg     <= gfpm_pkg::POINT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gfpm_pkg::REG_GATE_TICKS:     gate_ticks_reg     <= cfg_wdata;
                gfpm_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata[23:0];
                gfpm_pkg::REG_POINT_MASK:     point_mask_reg     <= cfg_wdata[15:0];
                default:                      ;
            endcase
        end
    end

    assign s_axis_tready = !queue_full;
    assign tick          = s_axis_tvalid && !queue_full;

    gfpm_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .signal_edge    (s_axis_tdata[0]),
        .button_level   (s_axis_tdata[1]),
        .gate_ticks     (gate_ticks_reg),
        .debounce_ticks (debounce_ticks_reg),
        .push           (push),
        .job            (push_job)
    );

    gfpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    gfpm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .point_mask     (point_mask_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .measured_count (measured_count),
        .period_mode    (period_mode),
        .seg_thousands  (seg_thousands),
        .seg_hundreds   (seg_hundreds),
        .seg_tens       (seg_tens),
        .seg_units      (seg_units),
        .point_position (point_position)
    );

    assign m_axis_tdata = {5'd0, point_position, seg_units, seg_tens, seg_hundreds,
                           seg_thousands, period_mode, measured_count};

endmodule
